// ----- hdl/gdd_pkg.sv -----
// Shared types, constants and calendar functions for the Gregorian date difference block.
`default_nettype none

package gdd_pkg;

   // Field widths
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int DNUM_W   = 23;
   localparam int DIFF_W   = 23;
   localparam int WIDE_W   = DNUM_W + 1;

   // Stream packing
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   // Divide by 25 as multiply by reciprocal: exact for operands below 43690
   localparam int            RECIP_SHIFT = 17;
   localparam int            OPND_W      = 13;
   localparam int            PROD_W      = 2 * OPND_W;
   localparam int            QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [12:0]   RECIP_25    = 13'd5243;
   localparam logic [12:0]   DIV_25      = 13'd25;

   localparam logic [8:0]    DAYS_PER_YEAR = 9'd365;
   localparam logic [14:0]   ROUND_4       = 15'd3;
   localparam logic [14:0]   ROUND_100     = 15'd99;
   localparam logic [14:0]   ROUND_400     = 15'd399;

   localparam logic signed [WIDE_W-1:0] DIFF_LIMIT = 24'sd3652425;

   // Month codes
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   // Per-stage advance enables of the day number pipeline
   typedef struct packed {
      logic s3;
      logic s2;
      logic s1;
   } stage_en_type;

   // Days of a common year before the first of the month
   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Length of the month, February by leap flag
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] r;
      if (m == MONTH_FEB) begin
         r = leap ? 5'd29 : 5'd28;
      end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
         r = 5'd30;
      end else begin
         r = 5'd31;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/gdd_day_number.sv -----
// Three-stage pipeline that turns one date into its day number and validity flag.
`default_nettype none

module gdd_day_number (
   input  wire logic                          clock,
   input  wire gdd_pkg::stage_en_type         stage_en,
   input  wire gdd_pkg::date_type             date,
   output logic [gdd_pkg::DNUM_W-1:0]         day_num,
   output logic                               date_valid
);
   import gdd_pkg::*;

   // Stage 1: reciprocal products and 365 * year
   logic [YEAR_W-1:0]  year1_ff;
   logic [MONTH_W-1:0] month1_ff;
   logic [DAY_W-1:0]   day1_ff;
   logic [DNUM_W-1:0]  y365_1_ff, y365_1_in;
   logic [PROD_W-1:0]  p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [14:0]        sum100, sum400;
   logic [OPND_W-1:0]  v0, v1, v2;

   always_comb begin
      v0     = {1'b0, date.year[YEAR_W-1:2]};
      sum100 = {1'b0, date.year} + ROUND_100;
      sum400 = {1'b0, date.year} + ROUND_400;
      v1     = sum100[14:2];
      v2     = sum400[14:2];
      p0_in  = PROD_W'(v0) * PROD_W'(RECIP_25);
      p1_in  = PROD_W'(v1) * PROD_W'(RECIP_25);
      p2_in  = PROD_W'(v2) * PROD_W'(RECIP_25);
      y365_1_in = DNUM_W'(date.year) * DNUM_W'(DAYS_PER_YEAR);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         year1_ff  <= date.year;
         month1_ff <= date.month;
         day1_ff   <= date.day;
         y365_1_ff <= y365_1_in;
         p0_ff     <= p0_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
      end
   end

   // Stage 2: leap count, leap flag, validity and in-year offset
   logic [DNUM_W-1:0] y365_2_ff;
   logic [12:0]       leaps_ff, leaps_in;
   logic [9:0]        part_ff, part_in;
   logic              valid2_ff, valid2_in;
   logic [QUOT_W-1:0] q0, q1, q2;
   logic [14:0]       sum4;
   logic [12:0]       q0x25;
   logic              century, leap;
   logic [DAY_W-1:0]  mlen;

   always_comb begin
      q0    = p0_ff[PROD_W-1:RECIP_SHIFT];
      q1    = p1_ff[PROD_W-1:RECIP_SHIFT];
      q2    = p2_ff[PROD_W-1:RECIP_SHIFT];
      sum4  = {1'b0, year1_ff} + ROUND_4;
      leaps_in = sum4[14:2] - 13'(q1) + 13'(q2 >> 2);
      q0x25   = 13'(q0) * DIV_25;
      century = ({1'b0, year1_ff[YEAR_W-1:2]} == q0x25);
      leap    = (year1_ff[1:0] == 2'd0) && (!century || (q0[1:0] == 2'd0));
      mlen    = month_len(month1_ff, leap);
      valid2_in = (month1_ff >= MONTH_JAN) && (month1_ff <= MONTH_DEC)
                  && (day1_ff != '0) && (day1_ff <= mlen);
      part_in = 10'(days_before_month(month1_ff))
                + 10'((leap && (month1_ff > MONTH_FEB)) ? 1'b1 : 1'b0)
                + 10'(day1_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         y365_2_ff <= y365_1_ff;
         leaps_ff  <= leaps_in;
         part_ff   <= part_in;
         valid2_ff <= valid2_in;
      end
   end

   // Stage 3: sum the day number
   logic [DNUM_W-1:0] dnum_ff, dnum_in;
   logic              valid3_ff;

   assign dnum_in = y365_2_ff + DNUM_W'(leaps_ff) + DNUM_W'(part_ff);

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         dnum_ff   <= dnum_in;
         valid3_ff <= valid2_ff;
      end
   end

   assign day_num    = dnum_ff;
   assign date_valid = valid3_ff;

endmodule

`default_nettype wire

// ----- hdl/gregorian_date_difference.sv -----
// Top level: stream wrapper and final subtract of the Gregorian date difference block.
//
// Usage:
//   req_ channel takes one item per accepted beat: a start and an end date
//   (day, month, year). rsp_ channel returns one item per request, in order:
//   the signed day count from start to end, saturated to +/-3652425, and a
//   validity flag for each date. The count is zero when either date is invalid.
//   An accepted item reaches rsp_tvalid through four register stages (three
//   day-number stages and the subtract/saturate output register), each holding
//   one item. Throughput is one item per cycle while rsp_tready stays high.
//   Each stage has its own valid bit and advances when it is empty or the
//   stage after it advances, so bubbles are squeezed out and req_tready stays
//   high while a result waits as long as some stage is free. When the
//   receiver holds rsp_tready low, the output item is held stable and the
//   pipeline fills; req_tready falls once all four stages are occupied.
//   Synchronous reset empties the pipeline; no item is in flight after it.
`default_nettype none

module gregorian_date_difference (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // start_day, start_month, start_year, end_day, end_month, end_year, zero pad
   input  wire logic [gdd_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // day_difference, start_valid, end_valid, zero pad
   output logic [gdd_pkg::RSP_DATA_W-1:0]          rsp_tdata
);
   import gdd_pkg::*;

   // Unpack request
   date_type start_date, end_date;
   assign start_date.day   = req_tdata[4:0];
   assign start_date.month = req_tdata[8:5];
   assign start_date.year  = req_tdata[22:9];
   assign end_date.day     = req_tdata[27:23];
   assign end_date.month   = req_tdata[31:28];
   assign end_date.year    = req_tdata[45:32];

   // Stage valids and enables
   logic [3:0] valid_ff, valid_in;
   logic [3:0] en;
   stage_en_type dn_en;

   always_comb begin
      en[3] = !valid_ff[3] || rsp_tready;
      en[2] = !valid_ff[2] || en[3];
      en[1] = !valid_ff[1] || en[2];
      en[0] = !valid_ff[0] || en[1];
      valid_in[0] = en[0] ? req_tvalid  : valid_ff[0];
      valid_in[1] = en[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = en[3] ? valid_ff[2] : valid_ff[3];
      dn_en.s1 = en[0];
      dn_en.s2 = en[1];
      dn_en.s3 = en[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en[0];

   // Day numbers of both dates
   logic [DNUM_W-1:0] start_dn, end_dn;
   logic              start_ok, end_ok;

   gdd_day_number u_start_dn (
      .clock      (clock),
      .stage_en   (dn_en),
      .date       (start_date),
      .day_num    (start_dn),
      .date_valid (start_ok)
   );

   gdd_day_number u_end_dn (
      .clock      (clock),
      .stage_en   (dn_en),
      .date       (end_date),
      .day_num    (end_dn),
      .date_valid (end_ok)
   );

   // Subtract, saturate and zero invalid pairs
   logic signed [WIDE_W-1:0] diff_wide;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic                     start_ok_ff, end_ok_ff;

   always_comb begin
      diff_wide = $signed({1'b0, end_dn}) - $signed({1'b0, start_dn});
      if (!(start_ok && end_ok)) begin
         diff_in = '0;
      end else if (diff_wide > DIFF_LIMIT) begin
         diff_in = DIFF_W'(DIFF_LIMIT);
      end else if (diff_wide < -DIFF_LIMIT) begin
         diff_in = DIFF_W'(-DIFF_LIMIT);
      end else begin
         diff_in = diff_wide[DIFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         diff_ff     <= diff_in;
         start_ok_ff <= start_ok;
         end_ok_ff   <= end_ok;
      end
   end

   assign rsp_tvalid = valid_ff[3];
   assign rsp_tdata  = {7'd0, end_ok_ff, start_ok_ff, diff_ff};

   // A nonzero difference needs both dates valid
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[22:0] != 23'd0)) |-> (rsp_tdata[23] && rsp_tdata[24]))
      else $error("nonzero difference with an invalid date");

   // Difference stays inside the saturation limits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (($signed(diff_ff) <= $signed(DIFF_W'(DIFF_LIMIT)))
                      && ($signed(diff_ff) >= $signed(DIFF_W'(-DIFF_LIMIT)))))
      else $error("difference outside saturation range");

   // Pipeline is empty after reset
   assert property (@(posedge clock) reset |=> (valid_ff == 4'd0))
      else $error("pipeline not empty after reset");

   // Ready is low only when every stage holds an item
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (valid_ff == 4'hF && !rsp_tready))
      else $error("input stalled with a free stage");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the Gregorian date difference block.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gdd_pkg::*;

   localparam int          HOLD_CYCLES   = 60;
   localparam int          ITEMS_A_PHASE = 413;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam longint      SPAN_LIMIT    = 3652425;
   localparam int          REPORT_MAX    = 10;

   // Expected answer for one pair of dates
   typedef struct packed {
      logic                    end_ok;
      logic                    start_ok;
      logic signed [DIFF_W-1:0] days;
   } span_result_type;

   // Predicts the day span of each accepted pair and checks answers in order
   class span_scoreboard;
      span_result_type pending_spans[$];
      int unsigned     faults;

      function bit leap_year(int unsigned y);
         return (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
      endfunction

      function int unsigned month_days(int unsigned m, int unsigned y);
         if (m == MONTH_FEB) return leap_year(y) ? 29 : 28;
         if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return 30;
         return 31;
      endfunction

      function bit date_valid(date_type dt);
         if (dt.month < MONTH_JAN || dt.month > MONTH_DEC) return 1'b0;
         return dt.day >= 1 && dt.day <= month_days(dt.month, dt.year);
      endfunction

      // Days since the start of year 0, counting year 0 as leap
      function longint day_count(date_type dt);
         longint      n;
         int unsigned y;
         int unsigned cum_days[13];
         cum_days = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
         y = dt.year;
         n = 365 * longint'(y) + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
         n += cum_days[dt.month];
         if (dt.month > MONTH_FEB && leap_year(y)) n += 1;
         return n + dt.day;
      endfunction

      // Note one accepted item and queue its expected answer
      function void note_dates(logic [REQ_DATA_W-1:0] data);
         date_type        from_date;
         date_type        to_date;
         span_result_type want;
         longint          span;
         from_date     = data[22:0];
         to_date       = data[45:23];
         want.start_ok = date_valid(from_date);
         want.end_ok   = date_valid(to_date);
         span          = 0;
         if (want.start_ok && want.end_ok) begin
            span = day_count(to_date) - day_count(from_date);
            if (span > SPAN_LIMIT) span = SPAN_LIMIT;
            else if (span < -SPAN_LIMIT) span = -SPAN_LIMIT;
         end
         want.days = span[DIFF_W-1:0];
         pending_spans.push_back(want);
      endfunction

      // Compare one accepted answer with the oldest expectation
      function void check_span(logic [RSP_DATA_W-1:0] data);
         span_result_type got;
         span_result_type want;
         got = data[DIFF_W+1:0];
         if (pending_spans.size() == 0) begin
            faults++;
            if (faults <= REPORT_MAX)
               $display("unexpected answer: days=%0d start_ok=%0b end_ok=%0b",
                        got.days, got.start_ok, got.end_ok);
            return;
         end
         want = pending_spans.pop_front();
         if (got.days !== want.days || got.start_ok !== want.start_ok ||
             got.end_ok !== want.end_ok) begin
            faults++;
            if (faults <= REPORT_MAX)
               $display("mismatch: days exp %0d got %0d,", want.days, got.days,
                        " start_ok exp %0b got %0b,", want.start_ok, got.start_ok,
                        " end_ok exp %0b got %0b", want.end_ok, got.end_ok);
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   span_scoreboard board = new();
   int unsigned    send_idle_pct  = 0;
   int unsigned    sink_stall_pct = 0;
   bit             hold_wanted    = 1'b0;
   int unsigned    cycle_count    = 0;

   gregorian_date_difference i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Check answers and drive rsp_tready, with one long hold-off
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_span(rsp_tdata);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   function automatic date_type make_date(int unsigned d, int unsigned m, int unsigned y);
      date_type dt;
      dt.day   = d[DAY_W-1:0];
      dt.month = m[MONTH_W-1:0];
      dt.year  = y[YEAR_W-1:0];
      return dt;
   endfunction

   // Mostly nominal years, some above 9999 and some century edges
   function automatic int unsigned pick_year();
      int unsigned roll;
      int unsigned edges[6];
      edges = '{0, 100, 400, 1900, 2000, 9999};
      roll  = $urandom_range(99);
      if (roll < 5) return $urandom_range(16383, 10000);
      if (roll < 10) return edges[$urandom_range(5)];
      return $urandom_range(9999);
   endfunction

   // Mostly well-formed dates, with month ends, bad days, bad months and raw bits
   function automatic date_type random_date(int unsigned y);
      date_type    dt;
      int unsigned roll;
      int unsigned len;
      int unsigned raw;
      roll = $urandom_range(99);
      if (roll < 8) begin
         raw = $urandom();
         dt  = raw[22:0];
         return dt;
      end
      dt.year  = y[YEAR_W-1:0];
      dt.month = 4'($urandom_range(12, 1));
      len      = board.month_days(dt.month, y);
      if (roll < 12) dt.month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
      if (roll < 18) dt.day = $urandom_range(1) ? 5'd0 : 5'(len + 1);
      else if (roll < 30) dt.day = len[DAY_W-1:0];
      else dt.day = 5'($urandom_range(len, 1));
      return dt;
   endfunction

   // Offer one item, idling at random first, and note it once accepted
   task automatic send_dates(input date_type from_date, input date_type to_date);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, to_date, from_date};
      do @(posedge clock); while (!req_tready);
      board.note_dates(req_tdata);
   endtask

   task automatic send_random_pair();
      int unsigned from_year;
      int unsigned to_year;
      from_year = pick_year();
      to_year   = pick_year();
      if ($urandom_range(99) < 30) begin
         to_year = from_year + $urandom_range(3);
         if ($urandom_range(1)) to_year = (from_year >= 3) ? from_year - 3 : 0;
         if (to_year > 16383) to_year = 16383;
      end
      send_dates(random_date(from_year), random_date(to_year));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: leap rules, bad dates, extremes and saturation
      send_dates(make_date(1, 1, 2000), make_date(1, 1, 2000));
      send_dates(make_date(28, 2, 2000), make_date(1, 3, 2000));
      send_dates(make_date(28, 2, 1900), make_date(1, 3, 1900));
      send_dates(make_date(29, 2, 2024), make_date(29, 2, 2000));
      send_dates(make_date(29, 2, 1900), make_date(1, 1, 1900));
      send_dates(make_date(1, 1, 2023), make_date(29, 2, 2023));
      send_dates(make_date(29, 2, 0), make_date(1, 3, 0));
      send_dates(make_date(0, 5, 2010), make_date(31, 12, 2010));
      send_dates(make_date(31, 4, 2010), make_date(30, 4, 2010));
      send_dates(make_date(15, 0, 1234), make_date(15, 13, 1234));
      send_dates(make_date(15, 15, 1234), make_date(15, 6, 1234));
      send_dates(make_date(1, 1, 0), make_date(31, 12, 9999));
      send_dates(make_date(31, 12, 9999), make_date(1, 1, 0));
      send_dates(make_date(1, 1, 0), make_date(31, 12, 16383));
      send_dates(make_date(31, 12, 16383), make_date(1, 1, 0));
      send_dates(make_date(31, 12, 16383), make_date(1, 1, 16383));
      send_dates(make_date(31, 12, 2020), make_date(1, 1, 2021));
      send_dates(make_date(15, 8, 2021), make_date(3, 7, 2021));
      send_dates(make_date(10, 10, 2500), make_date(10, 10, 1500));
      send_dates(make_date(31, 15, 16383), make_date(31, 15, 16383));
      send_dates(make_date(0, 0, 0), make_date(0, 0, 0));
      send_dates(make_date(1, 3, 10000), make_date(28, 2, 10400));

      // Random items in four idling phases; hold off the receiver early on
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin send_idle_pct = 46; sink_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  sink_stall_pct = 46; end
            default: begin send_idle_pct = 28; sink_stall_pct = 28; end
         endcase
         for (int i = 0; i < ITEMS_A_PHASE; i++) begin
            if (phase == 0 && i == 100) hold_wanted = 1'b1;
            send_random_pair();
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then give the pipeline time to show any stray answer
      while (board.pending_spans.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      if (board.faults == 0 && board.pending_spans.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
